// ===== sv/ica_pkg.sv =====
// Shared types and codes for the integer calculator ALU.
package ica_pkg;

  // Operation codes on the input beat.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZ    = 2'd1,
    ST_NEGROOT = 2'd2,
    ST_OVF     = 2'd3
  } status_e;

  // What a cell does to the beat passing through it.
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2,
    MODE_SQRT = 2'd3
  } mode_e;

  // How the end of the chain turns the working registers into a result.
  typedef enum logic [2:0] {
    KIND_DONE = 3'd0,
    KIND_MUL  = 3'd1,
    KIND_DIV  = 3'd2,
    KIND_SQRT = 3'd3,
    KIND_POW  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    mode_e   mode;
    status_e status;
    logic    neg;
    logic    ovf;
  } tag_t;

endpackage

// ===== sv/ica_in_if.sv =====
// Input channel of the integer calculator ALU.
interface ica_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

// ===== sv/ica_out_if.sv =====
// Result channel of the integer calculator ALU.
interface ica_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status_code;

  modport source (output valid, output result_value, output status_code, input ready);
  modport sink (input valid, input result_value, input status_code, output ready);
endinterface

// ===== sv/ica_cell.sv =====
// One step cell: a shift-add, restoring divide or root digit step, or a pass-through, registered.
module ica_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AUX_WIDTH  = 37,
  parameter int unsigned STEP       = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  ica_pkg::tag_t             tag_i,
  input  logic [2*DATA_WIDTH-1:0]   acc_i,
  input  logic [DATA_WIDTH-1:0]     x_i,
  input  logic [DATA_WIDTH-1:0]     y_i,
  input  logic [DATA_WIDTH-1:0]     q_i,
  input  logic [AUX_WIDTH-1:0]      aux_i,
  output logic                      vld_o,
  output ica_pkg::tag_t             tag_o,
  output logic [2*DATA_WIDTH-1:0]   acc_o,
  output logic [DATA_WIDTH-1:0]     x_o,
  output logic [DATA_WIDTH-1:0]     y_o,
  output logic [DATA_WIDTH-1:0]     q_o,
  output logic [AUX_WIDTH-1:0]      aux_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned SQ = W / 2;

  logic [2*W-1:0] acc_d;
  logic [W-1:0]   y_d;
  logic [W-1:0]   q_d;
  logic [W:0]     rem_div;
  logic [W:0]     dif_div;
  logic [W+1:0]   rem_sq;
  logic [W+1:0]   trial_sq;
  logic [W+1:0]   dif_sq;
  logic           vld_q;
  ica_pkg::tag_t  tag_q;
  logic [2*W-1:0] acc_q;
  logic [W-1:0]   x_q;
  logic [W-1:0]   y_q;
  logic [W-1:0]   q_q;
  logic [AUX_WIDTH-1:0] aux_q;

  assign rem_div  = {acc_i[W-1:0], y_i[W-1]};
  assign dif_div  = rem_div - {1'b0, x_i};
  assign rem_sq   = {acc_i[W-1:0], y_i[W-1:W-2]};
  assign trial_sq = {q_i, 2'b01};
  assign dif_sq   = rem_sq - trial_sq;

  always_comb begin
    acc_d = acc_i;
    y_d   = y_i;
    q_d   = q_i;
    unique case (tag_i.mode)
      ica_pkg::MODE_PASS: begin
      end
      ica_pkg::MODE_MUL: begin
        // MSB first: double and add the multiplicand when the bit is set
        acc_d = {acc_i[2*W-2:0], 1'b0} + {{W{1'b0}}, x_i & {W{y_i[W-1]}}};
        y_d   = {y_i[W-2:0], 1'b0};
      end
      ica_pkg::MODE_DIV: begin
        if (rem_div >= {1'b0, x_i}) begin
          acc_d = {{W{1'b0}}, dif_div[W-1:0]};
          q_d   = {q_i[W-2:0], 1'b1};
        end else begin
          acc_d = {{W{1'b0}}, rem_div[W-1:0]};
          q_d   = {q_i[W-2:0], 1'b0};
        end
        y_d = {y_i[W-2:0], 1'b0};
      end
      ica_pkg::MODE_SQRT: begin
        if (STEP < SQ) begin
          if (rem_sq >= trial_sq) begin
            acc_d = {{W{1'b0}}, dif_sq[W-1:0]};
            q_d   = {q_i[W-2:0], 1'b1};
          end else begin
            acc_d = {{W{1'b0}}, rem_sq[W-1:0]};
            q_d   = {q_i[W-2:0], 1'b0};
          end
          y_d = {y_i[W-3:0], 2'b00};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      acc_q <= acc_d;
      x_q   <= x_i;
      y_q   <= y_d;
      q_q   <= q_d;
      aux_q <= aux_i;
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign acc_o = acc_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign q_o   = q_q;
  assign aux_o = aux_q;
endmodule

// ===== sv/ica_link.sv =====
// Pass boundary: clamps a power product and sets up the next square or multiply.
module ica_link #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AUX_WIDTH  = 37,
  parameter int unsigned PASS       = 1
) (
  input  ica_pkg::tag_t             tag_i,
  input  logic [2*DATA_WIDTH-1:0]   acc_i,
  input  logic [DATA_WIDTH-1:0]     x_i,
  input  logic [DATA_WIDTH-1:0]     y_i,
  input  logic [AUX_WIDTH-1:0]      aux_i,
  output ica_pkg::tag_t             tag_o,
  output logic [2*DATA_WIDTH-1:0]   acc_o,
  output logic [DATA_WIDTH-1:0]     x_o,
  output logic [DATA_WIDTH-1:0]     y_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned EB = AUX_WIDTH - 1 - PASS / 2;
  localparam logic [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxV = ~MinV;

  logic [W-1:0] lim;
  logic         over;
  logic [W-1:0] r;

  assign lim  = tag_i.neg ? MinV : MaxV;
  assign over = acc_i > {{W{1'b0}}, lim};
  // Clamp just past the limit: later products can only grow
  assign r    = over ? lim + W'(1) : acc_i[W-1:0];

  always_comb begin
    tag_o = tag_i;
    acc_o = acc_i;
    x_o   = x_i;
    y_o   = y_i;
    if (tag_i.kind == ica_pkg::KIND_POW) begin
      tag_o.ovf = tag_i.ovf | over;
      if (PASS % 2 == 0) begin
        tag_o.mode = ica_pkg::MODE_MUL;
        acc_o      = '0;
        x_o        = r;
        y_o        = r;
      end else if (aux_i[EB]) begin
        tag_o.mode = ica_pkg::MODE_MUL;
        acc_o      = '0;
        x_o        = r;
        y_o        = aux_i[W-1:0];
      end else begin
        tag_o.mode = ica_pkg::MODE_PASS;
        acc_o      = {{W{1'b0}}, r};
      end
    end else begin
      tag_o.mode = ica_pkg::MODE_PASS;
    end
  end
endmodule

// ===== sv/integer_calculator_alu.sv =====
// Integer calculator ALU top level: decode, chain of step cells, result buffer.
//
// Usage notes
// - Input channel in_i carries opcode, operand_a, operand_b; a beat is taken
//   when valid and ready are both high. Result channel out_o returns one beat
//   per input beat, in order: result_value and status_code.
// - Throughput: one beat per cycle. Ready follows the registered buffer count
//   and drops only while the two-entry result buffer is full.
// - Stages: one decode stage, 2*clog2(DATA_WIDTH) passes of DATA_WIDTH step
//   cells, and the result buffer. Every operation walks the whole chain.
// - Pass 0 does the multiply, divide or root steps. The remaining passes
//   serve the power by square-and-multiply over the exponent bits.
// - Add, subtract and all special cases are settled in decode and ride
//   the chain unchanged.
// - Reset clears the valid flags of every stage and empties the buffer.
// - When the receiver stalls with two results held, the whole chain
//   freezes in place; nothing is dropped.
module integer_calculator_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  ica_in_if.sink     in_i,
  ica_out_if.source  out_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = $clog2(W);
  localparam int unsigned NP = 2 * PW;
  localparam int unsigned NC = NP * W;
  localparam int unsigned AW = W + PW;
  localparam logic [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxV = ~MinV;

  // Global advance: the chain moves whenever the buffer has room
  logic       en;
  logic [1:0] cnt_q;

  assign en        = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // ---------------------------------------------------------------- decode
  logic [63:0]   a64;
  logic [63:0]   b64;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic          sa;
  logic          sb;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W-1:0]  sum;
  logic [W-1:0]  diff;
  logic          neg_pow;

  ica_pkg::tag_t d_tag;
  logic [2*W-1:0] d_acc;
  logic [W-1:0]  d_x;
  logic [W-1:0]  d_y;
  logic [W-1:0]  d_q;
  logic [AW-1:0] d_aux;

  assign a64     = {{32{in_i.operand_a[31]}}, in_i.operand_a};
  assign b64     = {{32{in_i.operand_b[31]}}, in_i.operand_b};
  assign ua      = a64[W-1:0];
  assign ub      = b64[W-1:0];
  assign sa      = ua[W-1];
  assign sb      = ub[W-1];
  assign mag_a   = sa ? (~ua + W'(1)) : ua;
  assign mag_b   = sb ? (~ub + W'(1)) : ub;
  assign sum     = ua + ub;
  assign diff    = ua - ub;
  assign neg_pow = sa & ub[0];

  always_comb begin
    d_tag = '{kind: ica_pkg::KIND_DONE, mode: ica_pkg::MODE_PASS,
              status: ica_pkg::ST_OK, neg: 1'b0, ovf: 1'b0};
    d_acc = '0;
    d_x   = '0;
    d_y   = '0;
    d_q   = '0;
    d_aux = '0;
    unique case (in_i.opcode)
      ica_pkg::OP_ADD: begin
        d_q = sum;
        if (!(ua[W-1] ^ ub[W-1]) && (sum[W-1] ^ ua[W-1])) begin
          d_tag.status = ica_pkg::ST_OVF;
        end
      end
      ica_pkg::OP_SUB: begin
        d_q = diff;
        if ((ua[W-1] ^ ub[W-1]) && (diff[W-1] ^ ua[W-1])) begin
          d_tag.status = ica_pkg::ST_OVF;
        end
      end
      ica_pkg::OP_MUL: begin
        d_tag.kind = ica_pkg::KIND_MUL;
        d_tag.mode = ica_pkg::MODE_MUL;
        d_tag.neg  = sa ^ sb;
        d_x        = mag_a;
        d_y        = mag_b;
      end
      ica_pkg::OP_DIV: begin
        if (ub == '0) begin
          d_tag.status = ica_pkg::ST_DIVZ;
        end else if (ua == MinV && ub == '1) begin
          d_q          = MinV;
          d_tag.status = ica_pkg::ST_OVF;
        end else begin
          d_tag.kind = ica_pkg::KIND_DIV;
          d_tag.mode = ica_pkg::MODE_DIV;
          d_tag.neg  = sa ^ sb;
          d_x        = mag_b;
          d_y        = mag_a;
        end
      end
      ica_pkg::OP_POW: begin
        if (sb) begin
          // negative exponent: truncated real value
          if (ua == '0) begin
            d_tag.status = ica_pkg::ST_DIVZ;
          end else if (mag_a == W'(1)) begin
            d_q = neg_pow ? '1 : W'(1);
          end
        end else if (ub == '0) begin
          d_q = W'(1);
        end else if (mag_a <= W'(1)) begin
          d_q = (mag_a == '0) ? '0 : (neg_pow ? '1 : W'(1));
        end else if (ub >= W'(W)) begin
          d_tag.status = ica_pkg::ST_OVF;
          d_q          = neg_pow ? MinV : MaxV;
        end else begin
          d_tag.kind = ica_pkg::KIND_POW;
          d_tag.mode = ica_pkg::MODE_MUL;
          d_tag.neg  = neg_pow;
          d_x        = W'(1);
          d_y        = W'(1);
          d_aux      = {ub[PW-1:0], mag_a};
        end
      end
      ica_pkg::OP_SQRT: begin
        if (sa) begin
          d_tag.status = ica_pkg::ST_NEGROOT;
        end else begin
          d_tag.kind = ica_pkg::KIND_SQRT;
          d_tag.mode = ica_pkg::MODE_SQRT;
          // an odd width drops the clear sign bit so digit pairs line up
          d_y        = (W % 2 == 1) ? {ua[W-2:0], 1'b0} : ua;
        end
      end
      default: begin
      end
    endcase
  end

  logic           dec_vld_q;
  ica_pkg::tag_t  dec_tag_q;
  logic [2*W-1:0] dec_acc_q;
  logic [W-1:0]   dec_x_q;
  logic [W-1:0]   dec_y_q;
  logic [W-1:0]   dec_q_q;
  logic [AW-1:0]  dec_aux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
    end else if (en) begin
      dec_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec_tag_q <= d_tag;
      dec_acc_q <= d_acc;
      dec_x_q   <= d_x;
      dec_y_q   <= d_y;
      dec_q_q   <= d_q;
      dec_aux_q <= d_aux;
    end
  end

  // ---------------------------------------------------------------- chain
  logic           c_vld [NC+1];
  ica_pkg::tag_t  c_tag [NC+1];
  logic [2*W-1:0] c_acc [NC+1];
  logic [W-1:0]   c_x   [NC+1];
  logic [W-1:0]   c_y   [NC+1];
  logic [W-1:0]   c_q   [NC+1];
  logic [AW-1:0]  c_aux [NC+1];

  ica_pkg::tag_t  ci_tag [NC];
  logic [2*W-1:0] ci_acc [NC];
  logic [W-1:0]   ci_x   [NC];
  logic [W-1:0]   ci_y   [NC];

  ica_pkg::tag_t  l_tag [NP-1];
  logic [2*W-1:0] l_acc [NP-1];
  logic [W-1:0]   l_x   [NP-1];
  logic [W-1:0]   l_y   [NP-1];

  assign c_vld[0] = dec_vld_q;
  assign c_tag[0] = dec_tag_q;
  assign c_acc[0] = dec_acc_q;
  assign c_x[0]   = dec_x_q;
  assign c_y[0]   = dec_y_q;
  assign c_q[0]   = dec_q_q;
  assign c_aux[0] = dec_aux_q;

  for (genvar p = 0; p < NP; p++) begin : g_pass
    if (p > 0) begin : g_link
      ica_link #(
        .DATA_WIDTH (W),
        .AUX_WIDTH  (AW),
        .PASS       (p)
      ) u_link (
        .tag_i (c_tag[p*W]),
        .acc_i (c_acc[p*W]),
        .x_i   (c_x[p*W]),
        .y_i   (c_y[p*W]),
        .aux_i (c_aux[p*W]),
        .tag_o (l_tag[p-1]),
        .acc_o (l_acc[p-1]),
        .x_o   (l_x[p-1]),
        .y_o   (l_y[p-1])
      );
    end
    for (genvar j = 0; j < W; j++) begin : g_step
      if (p > 0 && j == 0) begin : g_head
        assign ci_tag[p*W+j] = l_tag[p-1];
        assign ci_acc[p*W+j] = l_acc[p-1];
        assign ci_x[p*W+j]   = l_x[p-1];
        assign ci_y[p*W+j]   = l_y[p-1];
      end else begin : g_body
        assign ci_tag[p*W+j] = c_tag[p*W+j];
        assign ci_acc[p*W+j] = c_acc[p*W+j];
        assign ci_x[p*W+j]   = c_x[p*W+j];
        assign ci_y[p*W+j]   = c_y[p*W+j];
      end
      ica_cell #(
        .DATA_WIDTH (W),
        .AUX_WIDTH  (AW),
        .STEP       (j)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .vld_i  (c_vld[p*W+j]),
        .tag_i  (ci_tag[p*W+j]),
        .acc_i  (ci_acc[p*W+j]),
        .x_i    (ci_x[p*W+j]),
        .y_i    (ci_y[p*W+j]),
        .q_i    (c_q[p*W+j]),
        .aux_i  (c_aux[p*W+j]),
        .vld_o  (c_vld[p*W+j+1]),
        .tag_o  (c_tag[p*W+j+1]),
        .acc_o  (c_acc[p*W+j+1]),
        .x_o    (c_x[p*W+j+1]),
        .y_o    (c_y[p*W+j+1]),
        .q_o    (c_q[p*W+j+1]),
        .aux_o  (c_aux[p*W+j+1])
      );
    end
  end

  // ---------------------------------------------------------------- finish
  ica_pkg::tag_t   fin_tag;
  logic [W-1:0]    fin_lim;
  logic            fin_over;
  logic [W-1:0]    fin_mag;
  logic [W-1:0]    fin_v;
  ica_pkg::status_e fin_st;
  logic signed [63:0] fin_v64;

  assign fin_tag  = c_tag[NC];
  assign fin_lim  = fin_tag.neg ? MinV : MaxV;
  assign fin_over = c_acc[NC] > {{W{1'b0}}, fin_lim};
  assign fin_mag  = c_acc[NC][W-1:0];

  always_comb begin
    fin_v  = c_q[NC];
    fin_st = fin_tag.status;
    unique case (fin_tag.kind)
      ica_pkg::KIND_DONE: begin
      end
      ica_pkg::KIND_MUL: begin
        // low bits of the magnitude product, signed, are the wrapped product
        fin_v  = fin_tag.neg ? (~fin_mag + W'(1)) : fin_mag;
        fin_st = fin_over ? ica_pkg::ST_OVF : ica_pkg::ST_OK;
      end
      ica_pkg::KIND_DIV: begin
        fin_v = fin_tag.neg ? (~c_q[NC] + W'(1)) : c_q[NC];
      end
      ica_pkg::KIND_SQRT: begin
        fin_v = c_q[NC];
      end
      ica_pkg::KIND_POW: begin
        if (fin_tag.ovf || fin_over) begin
          fin_v  = fin_tag.neg ? MinV : MaxV;
          fin_st = ica_pkg::ST_OVF;
        end else begin
          fin_v  = fin_tag.neg ? (~fin_mag + W'(1)) : fin_mag;
          fin_st = ica_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign fin_v64 = 64'(signed'(fin_v));

  // ---------------------------------------------------------------- result buffer
  logic             push;
  logic             pop;
  logic [31:0]      fq_res [2];
  ica_pkg::status_e fq_st  [2];

  assign push = c_vld[NC] & en;
  assign pop  = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      fq_res[0] <= fq_res[1];
      fq_st[0]  <= fq_st[1];
    end
    if (push) begin
      if (cnt_q == 2'd0 || (pop && cnt_q == 2'd1)) begin
        fq_res[0] <= fin_v64[31:0];
        fq_st[0]  <= fin_st;
      end else begin
        fq_res[1] <= fin_v64[31:0];
        fq_st[1]  <= fin_st;
      end
    end
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.result_value = fq_res[0];
  assign out_o.status_code  = fq_st[0];

  // ---------------------------------------------------------------- checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && c_vld[NC]) |=> (c_vld[NC] && $stable(c_q[NC]) && $stable(c_acc[NC])))
    else $error("chain moved while stalled");

  a_root_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_vld[NC] && fin_tag.kind == ica_pkg::KIND_SQRT) |-> fin_st == ica_pkg::ST_OK)
    else $error("root in the chain reported a fault");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full buffer changed without a pop");
endmodule

// ===== bench/ica_tb_if.sv =====
`timescale 1ns / 1ps
// Request and result records used by the integer calculator ALU bench.
package ica_tb_pkg;

  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } calc_req_t;

  typedef struct {
    logic signed [31:0] value;
    ica_pkg::status_e   status;
  } calc_res_t;
endpackage

// ===== bench/integer_calculator_alu_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the integer calculator ALU at DATA_WIDTH 32.
module integer_calculator_alu_tb;

  localparam int unsigned LATENCY   = 322;
  // Idle limit: the full chain latency plus long receiver stalls, several times over.
  localparam int unsigned WDOG_MAX  = 20000;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ica_in_if  in_bus ();
  ica_out_if out_bus ();

  integer_calculator_alu #(.DATA_WIDTH(32)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ica_tb_pkg::calc_req_t pending_ops[$];   // beats still to be sent
  ica_tb_pkg::calc_res_t expected_res[$];  // predicted results, oldest first

  int unsigned src_idle_pct = 18;
  int unsigned snk_idle_pct = 59;
  bit          hold_src     = 1'b0;
  bit          in_taken     = 1'b0;        // input beat taken at the last rising edge
  int unsigned n_sent, n_recv, n_err, idle_cycles;
  int unsigned op_seen[8];

  // ---------------------------------------------------------------------
  // Predictor: one result per beat, worked out in 64-bit arithmetic.
  // ---------------------------------------------------------------------
  function automatic ica_tb_pkg::calc_res_t calc_predict(ica_tb_pkg::calc_req_t rq);
    ica_tb_pkg::calc_res_t r;
    longint      a, b, w, acc, lim, mag, k;
    longint      s;
    bit          neg, ovf;
    a = rq.operand_a;
    b = rq.operand_b;
    r.value  = '0;
    r.status = ica_pkg::ST_OK;
    case (rq.opcode)
      ica_pkg::OP_ADD: begin
        w = a + b;
        r.value = w[31:0];
        if (w > MAXV || w < MINV) r.status = ica_pkg::ST_OVF;
      end
      ica_pkg::OP_SUB: begin
        w = a - b;
        r.value = w[31:0];
        if (w > MAXV || w < MINV) r.status = ica_pkg::ST_OVF;
      end
      ica_pkg::OP_MUL: begin
        // product of two 32-bit values fits in 64 bits signed
        w = a * b;
        r.value = w[31:0];
        if (w > MAXV || w < MINV) r.status = ica_pkg::ST_OVF;
      end
      ica_pkg::OP_DIV: begin
        if (b == 0) begin
          r.status = ica_pkg::ST_DIVZ;
        end else if (a == MINV && b == -1) begin
          r.value  = MINV;
          r.status = ica_pkg::ST_OVF;
        end else begin
          w = a / b;            // truncates toward zero
          r.value = w[31:0];
        end
      end
      ica_pkg::OP_POW: begin
        mag = (a < 0) ? -a : a;
        neg = (a < 0) && b[0];
        if (b < 0) begin
          if (a == 0) r.status = ica_pkg::ST_DIVZ;
          else if (mag == 1) r.value = neg ? -32'sd1 : 32'sd1;
        end else if (b == 0) begin
          r.value = 32'sd1;
        end else if (mag <= 1) begin
          r.value = (mag == 0) ? 32'sd0 : (neg ? -32'sd1 : 32'sd1);
        end else begin
          lim = neg ? 64'sd2147483648 : 64'sd2147483647;
          acc = 1;
          ovf = (b >= 32);
          for (k = 0; k < b && !ovf; k++) begin
            if (acc > lim / mag) ovf = 1'b1;
            else acc = acc * mag;
          end
          if (ovf) begin
            r.status = ica_pkg::ST_OVF;
            r.value  = neg ? MINV : MAXV;
          end else begin
            w = neg ? -acc : acc;
            r.value = w[31:0];
          end
        end
      end
      ica_pkg::OP_SQRT: begin
        if (a < 0) begin
          r.status = ica_pkg::ST_NEGROOT;
        end else begin
          // bitwise floor root, 16 result bits
          s = 0;
          for (int i = 15; i >= 0; i--)
            if ((s + (64'sd1 << i)) * (s + (64'sd1 << i)) <= a) s = s + (64'sd1 << i);
          r.value = s[31:0];
        end
      end
      default: ;   // spare opcodes give zero, ok
    endcase
    return r;
  endfunction

  task automatic queue_op(logic [2:0] op, logic signed [31:0] a, logic signed [31:0] b);
    ica_tb_pkg::calc_req_t rq;
    rq.opcode    = op;
    rq.operand_a = a;
    rq.operand_b = b;
    pending_ops.push_back(rq);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_err++;
    $display("MISMATCH beat %0d %s: got %h expected %h", n_recv, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the head of the queue, changes inputs on the falling edge.
  // A presented beat is held unchanged until it is taken.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.opcode    <= ica_pkg::OP_ADD;
      in_bus.operand_a <= '0;
      in_bus.operand_b <= '0;
    end else if (in_bus.valid && !in_taken) begin
      // beat still waiting for ready: keep it on the bus
    end else if (!hold_src && pending_ops.size() != 0 &&
                 $urandom_range(99) >= src_idle_pct) begin
      in_bus.valid     <= 1'b1;
      in_bus.opcode    <= pending_ops[0].opcode;
      in_bus.operand_a <= pending_ops[0].operand_a;
      in_bus.operand_b <= pending_ops[0].operand_b;
    end else begin
      in_bus.valid <= 1'b0;
    end
    out_bus.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: samples at the rising edge, predicts accepted beats, checks results.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    ica_tb_pkg::calc_req_t rq;
    ica_tb_pkg::calc_res_t want;
    bit                    beat_seen;
    beat_seen = 1'b0;
    in_taken  = 1'b0;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        rq.opcode    = in_bus.opcode;
        rq.operand_a = in_bus.operand_a;
        rq.operand_b = in_bus.operand_b;
        expected_res.push_back(calc_predict(rq));
        void'(pending_ops.pop_front());
        op_seen[rq.opcode]++;
        n_sent++;
        in_taken  = 1'b1;
        beat_seen = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        beat_seen = 1'b1;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected beat", out_bus.result_value, 'x);
        end else begin
          want = expected_res.pop_front();
          if (out_bus.result_value !== want.value)
            report_mismatch("result_value", out_bus.result_value, want.value);
          if (out_bus.status_code !== want.status)
            report_mismatch("status_code", 32'(out_bus.status_code), 32'(want.status));
        end
        n_recv++;
      end
      idle_cycles <= beat_seen ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog: no beat for %0d cycles", WDOG_MAX);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(5))
      0:       return $urandom_range(20) - 10;
      1:       return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
      2:       return $urandom_range(70000) - 35000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: directed corners, then three random phases of idling.
  // ---------------------------------------------------------------------
  initial begin
    logic [2:0]         op;
    int unsigned        sel;
    logic signed [31:0] b;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // corners: wrap on add/sub/mul, divide by zero, min/-1, power cases, roots
    queue_op(ica_pkg::OP_ADD,  MAXV, 32'sd1);
    queue_op(ica_pkg::OP_ADD,  MINV, -32'sd1);
    queue_op(ica_pkg::OP_SUB,  MINV, 32'sd1);
    queue_op(ica_pkg::OP_SUB,  32'sd5, 32'sd9);
    queue_op(ica_pkg::OP_MUL,  32'sd65536, 32'sd65536);
    queue_op(ica_pkg::OP_MUL,  MINV, -32'sd1);
    queue_op(ica_pkg::OP_MUL,  -32'sd65536, 32'sd32768);
    queue_op(ica_pkg::OP_DIV,  32'sd7, 32'sd0);
    queue_op(ica_pkg::OP_DIV,  MINV, -32'sd1);
    queue_op(ica_pkg::OP_DIV,  -32'sd7, 32'sd2);
    queue_op(ica_pkg::OP_POW,  32'sd0, 32'sd0);
    queue_op(ica_pkg::OP_POW,  32'sd0, -32'sd3);
    queue_op(ica_pkg::OP_POW,  -32'sd1, -32'sd5);
    queue_op(ica_pkg::OP_POW,  32'sd1, MINV);
    queue_op(ica_pkg::OP_POW,  32'sd5, -32'sd2);
    queue_op(ica_pkg::OP_POW,  -32'sd2, 32'sd31);
    queue_op(ica_pkg::OP_POW,  32'sd2, 32'sd31);
    queue_op(ica_pkg::OP_POW,  32'sd3, MAXV);
    queue_op(ica_pkg::OP_POW,  -32'sd3, 32'sd5);
    queue_op(ica_pkg::OP_SQRT, MAXV, 32'sd0);
    queue_op(ica_pkg::OP_SQRT, -32'sd1, 32'sd0);
    queue_op(ica_pkg::OP_SQRT, 32'sd0, 32'sd0);
    queue_op(3'd6,             MAXV, MINV);
    queue_op(3'd7,             -32'sd1, -32'sd1);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 59 : 0;
      snk_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < 125; i++) begin
        sel = $urandom_range(9);
        if (sel == 9)     op = 3'($urandom_range(7));
        else if (sel > 5) op = ica_pkg::OP_POW;
        else              op = 3'(sel);
        b = rand_operand();
        if (op == ica_pkg::OP_POW && $urandom_range(2) != 0) b = $urandom_range(34);
        queue_op(op, rand_operand(), b);
      end
      if (phase == 1) begin
        // sender holds off until the chain has emptied
        while (pending_ops.size() > 60) @(posedge clk_i);
        hold_src = 1'b1;
        while (expected_res.size() != 0 || in_bus.valid) @(posedge clk_i);
        hold_src = 1'b0;
      end
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("ran %0d beats: add %0d sub %0d mul %0d div %0d pow %0d root %0d spare %0d",
             n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5], op_seen[6] + op_seen[7]);
    $display("three idling phases plus a full drain hold-off; %0d results checked", n_recv);
    if (n_err == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_err, expected_res.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ica_pkg.sv
sv/ica_in_if.sv
sv/ica_out_if.sv
sv/ica_cell.sv
sv/ica_link.sv
sv/integer_calculator_alu.sv
bench/ica_tb_if.sv
bench/integer_calculator_alu_tb.sv
